[src/rbr_pkg.sv]
// Shared types and constants of the receive byte ring.
`timescale 1ns / 1ps

package rbr_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int FILL_W     = 10;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE       = 1'd1;

    // Overflow policies.
    localparam logic POLICY_DISCARD_OLDEST = 1'b0;
    localparam logic POLICY_DROP_NEW       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } rbr_state_t;

    typedef struct packed {
        logic latch_item;
        logic exec_item;
        logic load_out;
        logic cfg_write;
    } rbr_cmd_t;

    typedef struct packed {
        logic out_free;
    } rbr_stat_t;

endpackage

[src/rbr_ctrl.sv]
// Sequencer of the receive byte ring: accept, execute, load result.
`timescale 1ns / 1ps

module rbr_ctrl
    import rbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  rbr_stat_t stat,
    output rbr_cmd_t  cmd
);

    rbr_state_t state_reg;
    rbr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        cfg_ready      = 1'b0;
        cmd.latch_item = 1'b0;
        cmd.exec_item  = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.cfg_write  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cfg_ready      = 1'b1;
                cmd.latch_item = in_valid;
                cmd.cfg_write  = cfg_valid;
            end
            ST_EXEC:
            begin
                cmd.exec_item = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[src/rbr_datapath.sv]
// Ring storage, indices, statistics counters and output register.
`timescale 1ns / 1ps

module rbr_datapath
    import rbr_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbr_cmd_t              cmd,
    output rbr_stat_t             stat,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  line_error,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  stored,
    output logic                  pop_valid,
    output logic [BYTE_W-1:0]     pop_data,
    output logic [FILL_W-1:0]     fill_level,
    output logic [COUNT_W-1:0]    received_count,
    output logic [COUNT_W-1:0]    overflow_count,
    output logic [COUNT_W-1:0]    error_count
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int SZ_W  = $clog2(MAX_SLOTS + 1);
    localparam int RESET_SIZE = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

    logic [BYTE_W-1:0] store_mem [MAX_SLOTS];
    logic [BYTE_W-1:0] mem_q_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              err_reg;

    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [SZ_W-1:0]    size_reg, size_next;
    logic               policy_reg, policy_next;
    logic [COUNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [COUNT_W-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic [COUNT_W-1:0] err_cnt_reg, err_cnt_next;
    logic               stored_flag_reg, stored_flag_next;
    logic               pop_flag_reg, pop_flag_next;
    logic               out_valid_reg;

    logic [IDX_W-1:0]  wr_adv;
    logic [IDX_W-1:0]  rd_adv;
    logic [SZ_W-1:0]   wr_inc;
    logic [SZ_W-1:0]   rd_inc;
    logic              ring_full;
    logic              mem_we;
    logic [SZ_W-1:0]   size_clamped;
    logic [SZ_W-1:0]   fill;

    // Index advance with wrap at the ring size in use.
    assign wr_inc = SZ_W'(wr_idx_reg) + SZ_W'(1);
    assign rd_inc = SZ_W'(rd_idx_reg) + SZ_W'(1);
    assign wr_adv = (wr_inc >= size_reg) ? '0 : IDX_W'(wr_inc);
    assign rd_adv = (rd_inc >= size_reg) ? '0 : IDX_W'(rd_inc);
    assign ring_full = (wr_adv == rd_idx_reg);

    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(2))
        begin
            size_clamped = SZ_W'(2);
        end
        else if (32'(cfg_data) > 32'(MAX_SLOTS))
        begin
            size_clamped = SZ_W'(MAX_SLOTS);
        end
        else
        begin
            size_clamped = SZ_W'(cfg_data);
        end
    end

    always_comb
    begin
        wr_idx_next      = wr_idx_reg;
        rd_idx_next      = rd_idx_reg;
        size_next        = size_reg;
        policy_next      = policy_reg;
        rx_cnt_next      = rx_cnt_reg;
        ovf_cnt_next     = ovf_cnt_reg;
        err_cnt_next     = err_cnt_reg;
        stored_flag_next = stored_flag_reg;
        pop_flag_next    = pop_flag_reg;
        mem_we           = 1'b0;

        if (cmd.cfg_write)
        begin
            case (cfg_index)
                REG_OVERFLOW_POLICY:
                begin
                    policy_next = cfg_data[0];
                end
                REG_RING_SIZE:
                begin
                    // A new size empties the ring; the counters are kept.
                    if (size_clamped != size_reg)
                    begin
                        size_next   = size_clamped;
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                    end
                end
                default:
                begin
                    policy_next = policy_reg;
                end
            endcase
        end

        if (cmd.exec_item)
        begin
            stored_flag_next = 1'b0;
            pop_flag_next    = 1'b0;
            case (kind_reg)
                KIND_PUSH:
                begin
                    if (err_reg)
                    begin
                        err_cnt_next = err_cnt_reg + 32'd1;
                    end
                    if (ring_full)
                    begin
                        ovf_cnt_next = ovf_cnt_reg + 32'd1;
                    end
                    if (!ring_full || policy_reg == POLICY_DISCARD_OLDEST)
                    begin
                        if (ring_full)
                        begin
                            rd_idx_next = rd_adv;
                        end
                        mem_we           = 1'b1;
                        wr_idx_next      = wr_adv;
                        rx_cnt_next      = rx_cnt_reg + 32'd1;
                        stored_flag_next = 1'b1;
                    end
                end
                KIND_POP:
                begin
                    // The byte at the read index is captured by the store
                    // read port at this same edge.
                    if (rd_idx_reg != wr_idx_reg)
                    begin
                        pop_flag_next = 1'b1;
                        rd_idx_next   = rd_adv;
                    end
                end
                KIND_CLEAR:
                begin
                    rx_cnt_next  = '0;
                    ovf_cnt_next = '0;
                    err_cnt_next = '0;
                end
                default:
                begin
                    stored_flag_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            size_reg        <= SZ_W'(RESET_SIZE);
            policy_reg      <= POLICY_DISCARD_OLDEST;
            rx_cnt_reg      <= '0;
            ovf_cnt_reg     <= '0;
            err_cnt_reg     <= '0;
            stored_flag_reg <= 1'b0;
            pop_flag_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wr_idx_reg      <= wr_idx_next;
            rd_idx_reg      <= rd_idx_next;
            size_reg        <= size_next;
            policy_reg      <= policy_next;
            rx_cnt_reg      <= rx_cnt_next;
            ovf_cnt_reg     <= ovf_cnt_next;
            err_cnt_reg     <= err_cnt_next;
            stored_flag_reg <= stored_flag_next;
            pop_flag_reg    <= pop_flag_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            kind_reg <= kind;
            data_reg <= data_byte;
            err_reg  <= line_error;
        end
    end

    // The read data is held from the execute cycle until the result is loaded.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_idx_reg] <= data_reg;
        end
        if (cmd.exec_item)
        begin
            mem_q_reg <= store_mem[rd_idx_reg];
        end
    end

    assign fill = (wr_idx_reg >= rd_idx_reg)
                ? SZ_W'(wr_idx_reg) - SZ_W'(rd_idx_reg)
                : SZ_W'(wr_idx_reg) + size_reg - SZ_W'(rd_idx_reg);

    // Output word register; it is loaded once the previous word is gone.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            stored         <= stored_flag_reg;
            pop_valid      <= pop_flag_reg;
            pop_data       <= pop_flag_reg ? mem_q_reg : '0;
            fill_level     <= FILL_W'(fill);
            received_count <= rx_cnt_reg;
            overflow_count <= ovf_cnt_reg;
            error_count    <= err_cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

endmodule

[src/rx_byte_ring_with_overflow_policy_unit.sv]
// Top level of the receive byte ring with selectable overflow policy.
`timescale 1ns / 1ps

// Receive ring of one serial port. Each input word is a push, a pop or a
// counter clear, and each produces exactly one result word that reports the
// outcome, the fill level and the three statistics counters. An item is
// accepted, then the ring indices and counters update and the byte store is
// written through its write port or read through its registered read port,
// and then the result is loaded into the output register. The output
// register lets the next item be accepted while a result still waits;
// loading stalls only while that register is still occupied. Configuration
// writes are taken whenever no item is in flight; changing the ring size
// empties the ring.
module rx_byte_ring_with_overflow_policy_unit
    import rbr_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  line_error,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  stored,
    output logic                  pop_valid,
    output logic [BYTE_W-1:0]     pop_data,
    output logic [FILL_W-1:0]     fill_level,
    output logic [COUNT_W-1:0]    received_count,
    output logic [COUNT_W-1:0]    overflow_count,
    output logic [COUNT_W-1:0]    error_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rbr_cmd_t  cmd;
    rbr_stat_t stat;

    rbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rbr_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .data_byte      (data_byte),
        .line_error     (line_error),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stored         (stored),
        .pop_valid      (pop_valid),
        .pop_data       (pop_data),
        .fill_level     (fill_level),
        .received_count (received_count),
        .overflow_count (overflow_count),
        .error_count    (error_count)
    );

endmodule
